### hdl/spnh_pkg.sv
`timescale 1ns / 1ps

package spnh_pkg;

  // Default sizing of the block.
  localparam int MAX_NODES_DEF   = 64;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int COST_BITS_DEF   = 22;

  // Fixed field widths on the ports.
  localparam int KIND_W   = 2;
  localparam int NODE_W   = 6;
  localparam int LEN_IN_W = 16;
  localparam int CFG_W    = 7;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_CONNECT = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_RUN     = 2'd3
  } kind_t;

  // Per-node flags entering the relaxation unit.
  typedef struct packed {
    logic valid;
    logic adj;
    logic reached;
    logic visited;
  } s1_flags_t;

  // Decision leaving the relaxation unit.
  typedef struct packed {
    logic upd;
    logic cand;
  } relax_flags_t;

endpackage

### hdl/spnh_relax_unit.sv
`timescale 1ns / 1ps

module spnh_relax_unit import spnh_pkg::*; #(
  parameter int IDX_W       = $clog2(MAX_NODES_DEF),
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  s1_flags_t              in_flags,
  input  logic [IDX_W-1:0]       in_idx,
  input  logic [COST_BITS-1:0]   base_cost,
  input  logic [LENGTH_BITS-1:0] seg_len,
  input  logic [COST_BITS-1:0]   old_cost,
  output logic                   out_valid,
  output logic [IDX_W-1:0]       out_idx,
  output logic [COST_BITS-1:0]   out_cost,
  output relax_flags_t           out_flags
);

  localparam int SUM_W = ((COST_BITS > LENGTH_BITS) ? COST_BITS : LENGTH_BITS) + 1;

  logic [SUM_W-1:0]     sum;
  logic [COST_BITS-1:0] nc;

  logic [COST_BITS-1:0] st_nc;
  logic [COST_BITS-1:0] st_old;
  logic                 st_adj;
  logic                 st_reached;
  logic                 st_visited;
  logic                 upd;
  logic                 eff_reached;

  // Saturating add of the selected node's cost and the entered node's length.
  always_comb begin
    sum = SUM_W'(base_cost) + SUM_W'(seg_len);
    if ((sum >> COST_BITS) != '0) begin
      nc = '1;
    end else begin
      nc = sum[COST_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_flags.valid;
    end
    out_idx    <= in_idx;
    st_nc      <= nc;
    st_old     <= old_cost;
    st_adj     <= in_flags.adj;
    st_reached <= in_flags.reached;
    st_visited <= in_flags.visited;
  end

  // Relax only on a strictly shorter path; the result feeds the next selection.
  always_comb begin
    upd             = out_valid & st_adj & (~st_reached | (st_nc < st_old));
    eff_reached     = st_reached | upd;
    out_cost        = upd ? st_nc : st_old;
    out_flags.upd   = upd;
    out_flags.cand  = out_valid & eff_reached & ~st_visited;
  end

endmodule

### hdl/shortest_path_next_hop_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ------------------------------------------
// cfg       in         cfg_wr_en (no wait)       cfg_wr_data = node_count
// in        in         in_valid / in_ready       kind, node, neighbor, length
// out       out        out_valid / out_ready     dest, predecessor, first_hop, path_cost,
//                                                reachable, last
//
// A length load and a clear of all connections complete without leaving the idle state;
// adding a connection also reads, modifies and writes one adjacency row. A run makes one
// search pass per reached node and then emits one result per node in use; each pass of
// the shared relaxation unit walks every node in use once. Reset is synchronous and active
// high; it forgets all lengths and connections through per-entry valid bits, so no clearing
// pass is needed. The block takes one item at a time: in_ready is high only when it is
// idle, and a result waits in the output register for as long as out_ready stays low.

module shortest_path_next_hop_core import spnh_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int COST_BITS   = COST_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [NODE_W-1:0]    node,
  input  logic [NODE_W-1:0]    neighbor,
  input  logic [LEN_IN_W-1:0]  length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NODE_W-1:0]    dest,
  output logic [NODE_W-1:0]    predecessor,
  output logic [NODE_W-1:0]    first_hop,
  output logic [COST_BITS-1:0] path_cost,
  output logic                 reachable,
  output logic                 last
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADJ_WR,
    S_SETUP,
    S_PASS,
    S_DRAIN,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] node_count;
  logic [CNT_W-1:0] n_use;
  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_end;

  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] nb_idx;
  logic             in_acc;
  logic             node_ok;
  logic             nb_ok;
  logic             src_ok;

  // Search state.
  logic [MAX_NODES-1:0] reached;
  logic [MAX_NODES-1:0] visited;
  logic [MAX_NODES-1:0] seg_ok;
  logic [MAX_NODES-1:0] row_valid;
  logic [IDX_W-1:0]     u;
  logic [IDX_W-1:0]     src;
  logic [COST_BITS-1:0] du;
  logic                 row_ok;
  logic                 found;
  logic [IDX_W-1:0]     min_idx;
  logic [COST_BITS-1:0] min_cost;
  logic [IDX_W-1:0]     conn_row;
  logic [IDX_W-1:0]     conn_col;

  // First stage of the relaxation pipeline.
  s1_flags_t        s1_flags;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_seg_ok;

  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic [COST_BITS-1:0] s2_cost;
  relax_flags_t       s2_flags;

  // Memories and their ports.
  logic [LENGTH_BITS-1:0] seg_mem  [MAX_NODES];
  logic [MAX_NODES-1:0]   adj_mem  [MAX_NODES];
  logic [COST_BITS-1:0]   best_mem [MAX_NODES];
  logic [IDX_W-1:0]       pred_mem [MAX_NODES];
  logic [IDX_W-1:0]       hop_mem  [MAX_NODES];

  logic [LENGTH_BITS-1:0] seg_rd;
  logic [MAX_NODES-1:0]   adj_rd;
  logic [COST_BITS-1:0]   best_rd;
  logic [IDX_W-1:0]       pred_rd;
  logic [IDX_W-1:0]       hop_rd;

  logic                 seg_we;
  logic                 adj_re;
  logic [IDX_W-1:0]     adj_ra;
  logic                 adj_we;
  logic [MAX_NODES-1:0] adj_wd;
  logic                 best_re;
  logic                 hop_re;
  logic [IDX_W-1:0]     hop_ra;
  logic                 pred_re;
  logic                 node_we;
  logic [IDX_W-1:0]     node_wa;
  logic [COST_BITS-1:0] best_wd;
  logic [IDX_W-1:0]     pred_wd;
  logic [IDX_W-1:0]     hop_wd;

  logic [LENGTH_BITS-1:0] len_eff;
  logic                   emit_ok;

  // Node count: zero acts as one, anything above the storage acts as the storage size.
  always_comb begin
    if (node_count == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(node_count) > MAX_NODES) begin
      n_use = CNT_W'(MAX_NODES);
    end else begin
      n_use = CNT_W'(node_count);
    end
  end

  assign scan_idx = scan_cnt[IDX_W-1:0];
  assign scan_end = (scan_cnt == (n_use - CNT_W'(1)));
  assign in_idx   = IDX_W'(node);
  assign nb_idx   = IDX_W'(neighbor);
  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign node_ok  = (int'(node) < MAX_NODES);
  assign nb_ok    = (int'(neighbor) < MAX_NODES);
  assign src_ok   = (int'(node) < int'(n_use));

  // Memory port control.
  always_comb begin
    seg_we  = in_acc && (kind == KIND_LOAD) && node_ok;
    adj_re  = 1'b0;
    adj_ra  = u;
    if (in_acc && (kind == KIND_CONNECT)) begin
      adj_re = 1'b1;
      adj_ra = in_idx;
    end else if (state == S_SETUP) begin
      adj_re = 1'b1;
    end
    adj_we  = (state == S_ADJ_WR);
    adj_wd  = (row_valid[conn_row] ? adj_rd : '0) | (MAX_NODES'(1) << conn_col);
    best_re = (state == S_PASS) || (state == S_EMIT_RD);
    pred_re = (state == S_EMIT_RD);
    hop_re  = (state == S_SETUP) || (state == S_EMIT_RD);
    hop_ra  = (state == S_SETUP) ? u : scan_idx;

    // An in-use source is seeded when the run item is taken; later writes come from relaxation.
    node_we = 1'b0;
    node_wa = s2_idx;
    best_wd = s2_cost;
    pred_wd = u;
    hop_wd  = (u == src) ? s2_idx : hop_rd;
    if (in_acc && (kind == KIND_RUN) && src_ok) begin
      node_we = 1'b1;
      node_wa = in_idx;
      best_wd = '0;
      pred_wd = in_idx;
      hop_wd  = in_idx;
    end else if (s2_flags.upd) begin
      node_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[in_idx] <= LENGTH_BITS'(length);
    end
    if (state == S_PASS) begin
      seg_rd <= seg_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[conn_row] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      best_mem[node_wa] <= best_wd;
      pred_mem[node_wa] <= pred_wd;
      hop_mem[node_wa]  <= hop_wd;
    end
    if (best_re) begin
      best_rd <= best_mem[scan_idx];
    end
    if (pred_re) begin
      pred_rd <= pred_mem[scan_idx];
    end
    if (hop_re) begin
      hop_rd <= hop_mem[hop_ra];
    end
  end

  // A length never loaded since reset reads as zero.
  assign len_eff = s1_seg_ok ? seg_rd : '0;

  spnh_relax_unit #(
    .IDX_W       (IDX_W),
    .LENGTH_BITS (LENGTH_BITS),
    .COST_BITS   (COST_BITS)
  ) u_relax (
    .clk       (clk),
    .rst       (rst),
    .in_flags  (s1_flags),
    .in_idx    (s1_idx),
    .base_cost (du),
    .seg_len   (len_eff),
    .old_cost  (best_rd),
    .out_valid (s2_valid),
    .out_idx   (s2_idx),
    .out_cost  (s2_cost),
    .out_flags (s2_flags)
  );

  assign emit_ok = reached[scan_idx];

  // Sequencer. Each pass relaxes the successors of node u and, from the values it leaves
  // behind, picks the cheapest reached and unvisited node for the next pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      node_count     <= NODE_COUNT_RST;
      out_valid      <= 1'b0;
      seg_ok         <= '0;
      row_valid      <= '0;
      reached        <= '0;
      visited        <= '0;
      found          <= 1'b0;
      s1_flags.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end

      s1_flags.valid <= 1'b0;

      if (s2_flags.upd) begin
        reached[s2_idx] <= 1'b1;
      end
      if (s2_flags.cand && (!found || (s2_cost < min_cost))) begin
        found    <= 1'b1;
        min_idx  <= s2_idx;
        min_cost <= s2_cost;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (kind_t'(kind))
              KIND_LOAD: begin
                if (node_ok) begin
                  seg_ok[in_idx] <= 1'b1;
                end
              end
              KIND_CONNECT: begin
                conn_row <= in_idx;
                conn_col <= nb_idx;
                if (node_ok && nb_ok) begin
                  state <= S_ADJ_WR;
                end
              end
              KIND_CLEAR: begin
                row_valid <= '0;
              end
              KIND_RUN: begin
                visited  <= '0;
                scan_cnt <= '0;
                src      <= in_idx;
                u        <= in_idx;
                du       <= '0;
                if (src_ok) begin
                  reached <= MAX_NODES'(1) << in_idx;
                  state   <= S_SETUP;
                end else begin
                  reached <= '0;
                  state   <= S_EMIT_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_ADJ_WR: begin
          row_valid[conn_row] <= 1'b1;
          state               <= S_IDLE;
        end

        S_SETUP: begin
          visited[u] <= 1'b1;
          row_ok     <= row_valid[u];
          found      <= 1'b0;
          scan_cnt   <= '0;
          state      <= S_PASS;
        end

        S_PASS: begin
          s1_flags.valid   <= 1'b1;
          s1_flags.adj     <= row_ok & adj_rd[scan_idx];
          s1_flags.reached <= reached[scan_idx];
          s1_flags.visited <= visited[scan_idx];
          s1_seg_ok        <= seg_ok[scan_idx];
          s1_idx           <= scan_idx;
          if (scan_end) begin
            state <= S_DRAIN;
          end else begin
            scan_cnt <= scan_cnt + CNT_W'(1);
          end
        end

        S_DRAIN: begin
          // The selection is final once both pipeline stages are empty.
          if (!s1_flags.valid && !s2_valid) begin
            if (found) begin
              u     <= min_idx;
              du    <= min_cost;
              state <= S_SETUP;
            end else begin
              scan_cnt <= '0;
              state    <= S_EMIT_RD;
            end
          end
        end

        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end

        S_EMIT_LD: begin
          dest        <= NODE_W'(scan_idx);
          predecessor <= emit_ok ? NODE_W'(pred_rd) : '0;
          first_hop   <= emit_ok ? NODE_W'(hop_rd) : '0;
          path_cost   <= emit_ok ? best_rd : '1;
          reachable   <= emit_ok;
          last        <= scan_end;
          out_valid   <= 1'b1;
          state       <= S_EMIT_OUT;
        end

        S_EMIT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              scan_cnt <= scan_cnt + CNT_W'(1);
              state    <= S_EMIT_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// The block is checked against a predictor that runs the same dense search over its own copy
// of the node lengths and the connection table. Every accepted item updates that copy or, for
// a run, appends the routes it should produce to a queue; a monitor pops the queue on each
// accepted result and compares the fields one by one.
module testbench;
  import spnh_pkg::*;

  localparam int COST_W = COST_BITS_DEF;
  localparam int NODES = MAX_NODES_DEF;
  localparam logic [COST_W-1:0] COST_TOP = {COST_W{1'b1}};

  // A connection item keeps the block busy with its row write after acceptance and yields no
  // result, so the block is given SETTLE_CYCLES spare cycles before the node count is changed.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 400000;
  localparam longint TIMEOUT_NS = 64'd20_000_000;
  localparam int SHOWN_MAX = 10;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 15;

  typedef struct packed {
    logic [NODE_W-1:0] dest;
    logic [NODE_W-1:0] pred;
    logic [NODE_W-1:0] hop;
    logic [COST_W-1:0] cost;
    logic reach;
    logic last;
  } route_t;

  typedef struct packed {
    logic cfg_first;
    logic [CFG_W-1:0] cfg_value;
    kind_t kind;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] neighbor;
    logic [LEN_IN_W-1:0] length;
    logic typed;
    route_t want;
  } stim_row_t;

  // Single-node runs whose outcome is plain: the source alone at cost zero, or a source that
  // is not in use, which leaves node zero unreachable.
  localparam route_t SOLO_SOURCE = '{dest: '0, pred: '0, hop: '0, cost: '0, reach: 1'b1,
                                     last: 1'b1};
  localparam route_t SOLO_LOST = '{dest: '0, pred: '0, hop: '0, cost: COST_TOP, reach: 1'b0,
                                   last: 1'b1};
  localparam route_t NO_ROUTE = '0;

  // Directed part. Small graph over six nodes: node 1 is expensive, nodes 3 and 4 tie at the
  // same cost from node 2, node 5 closes a loop back to the source, node 3 loops onto itself,
  // and node 0 also points at node 63, which is only in use once the count is raised.
  localparam int DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b0, 7'd0,   KIND_RUN,     6'd0,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b1, 7'd1,   KIND_RUN,     6'd0,  6'd0,  16'd0,     1'b1, SOLO_SOURCE},
    '{1'b0, 7'd0,   KIND_RUN,     6'd63, 6'd0,  16'd0,     1'b1, SOLO_LOST},
    '{1'b1, 7'd0,   KIND_RUN,     6'd0,  6'd0,  16'd0,     1'b1, SOLO_SOURCE},
    '{1'b1, 7'd6,   KIND_LOAD,    6'd1,  6'd0,  16'hFFFF,  1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_LOAD,    6'd2,  6'd63, 16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_LOAD,    6'd3,  6'd0,  16'd7,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_LOAD,    6'd4,  6'd0,  16'd7,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_LOAD,    6'd5,  6'd0,  16'd1,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_LOAD,    6'd63, 6'd0,  16'hFFFF,  1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd0,  6'd1,  16'hFFFF,  1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd0,  6'd2,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd2,  6'd3,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd2,  6'd4,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd3,  6'd5,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd4,  6'd5,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd3,  6'd3,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd0,  6'd63, 16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CONNECT, 6'd5,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_RUN,     6'd0,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_RUN,     6'd2,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_RUN,     6'd63, 6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b1, 7'd127, KIND_RUN,     6'd0,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_CLEAR,   6'd0,  6'd0,  16'd0,     1'b0, NO_ROUTE},
    '{1'b0, 7'd0,   KIND_RUN,     6'd0,  6'd63, 16'hFFFF,  1'b0, NO_ROUTE}
  };

  // Node counts of the random phases, the out-of-range values among them.
  localparam logic [CFG_W-1:0] PHASE_COUNTS [PHASES] = '{
    7'd64, 7'd1, 7'd5, 7'd127, 7'd12, 7'd0, 7'd33, 7'd9
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [NODE_W-1:0] node = '0;
  logic [NODE_W-1:0] neighbor = '0;
  logic [LEN_IN_W-1:0] length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NODE_W-1:0] dest;
  logic [NODE_W-1:0] predecessor;
  logic [NODE_W-1:0] first_hop;
  logic [COST_W-1:0] path_cost;
  logic reachable;
  logic last;

  // Predictor copy of the block's tables and its one register.
  logic [LEN_IN_W-1:0] seg_len [NODES];
  logic [NODES-1:0] links [NODES];
  logic [CFG_W-1:0] node_count_q = NODE_COUNT_RST;

  route_t pending_routes[$];
  int error_count = 0;

  // Idling of the two sides, in percent of cycles.
  int gap_pct = 0;
  int stall_pct = 0;

  shortest_path_next_hop_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .node(node),
    .neighbor(neighbor),
    .length(length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dest(dest),
    .predecessor(predecessor),
    .first_hop(first_hop),
    .path_cost(path_cost),
    .reachable(reachable),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random; a new decision is taken at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // A count of zero behaves as one node, anything above the table size as the full table.
  function automatic int nodes_used(input logic [CFG_W-1:0] count);
    if (count == 0) return 1;
    if (count > NODES) return NODES;
    return int'(count);
  endfunction

  // Dense search from src over the nodes in use: pick the cheapest reached node that is not
  // yet settled (lowest index wins a tie), then relax its successors on a strictly shorter
  // path only. The entry cost of a node is its own length; sums saturate. One route per node
  // in use is queued, node zero first.
  task automatic predict_routes(input logic [NODE_W-1:0] src);
    int n;
    int iter;
    int i;
    int u;
    bit found;
    logic [COST_W-1:0] du;
    logic [COST_W:0] sum;
    logic [COST_W-1:0] cand;
    logic [COST_W-1:0] cost_to [NODES];
    logic [NODE_W-1:0] prev [NODES];
    logic [NODE_W-1:0] hop [NODES];
    bit [NODES-1:0] done;
    bit [NODES-1:0] seen;
    route_t r;
    n = nodes_used(node_count_q);
    done = '0;
    seen = '0;
    for (i = 0; i < NODES; i++) begin
      cost_to[i] = '0;
      prev[i] = '0;
      hop[i] = '0;
    end
    if (int'(src) < n) begin
      prev[src] = src;
      hop[src] = src;
      seen[src] = 1'b1;
      for (iter = 0; iter < n; iter++) begin
        found = 1'b0;
        u = 0;
        du = '0;
        for (i = 0; i < n; i++) begin
          if (seen[i] && !done[i] && (!found || cost_to[i] < du)) begin
            found = 1'b1;
            u = i;
            du = cost_to[i];
          end
        end
        if (!found) break;
        done[u] = 1'b1;
        for (i = 0; i < n; i++) begin
          if (links[u][i]) begin
            sum = {1'b0, du} + (COST_W + 1)'(seg_len[i]);
            cand = (sum > COST_TOP) ? COST_TOP : sum[COST_W-1:0];
            if (!seen[i] || cand < cost_to[i]) begin
              seen[i] = 1'b1;
              cost_to[i] = cand;
              prev[i] = NODE_W'(u);
              hop[i] = (u == int'(src)) ? NODE_W'(i) : hop[u];
            end
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      r.dest = NODE_W'(i);
      r.pred = seen[i] ? prev[i] : '0;
      r.hop = seen[i] ? hop[i] : '0;
      r.cost = seen[i] ? cost_to[i] : COST_TOP;
      r.reach = seen[i];
      r.last = (i == n - 1);
      pending_routes = {pending_routes, r};
    end
  endtask

  // Present one item at a falling edge, after a random gap, and hold it until the block takes
  // it. Once accepted, the predictor applies the same item. A typed run pushes its result as
  // written in the table instead of asking the predictor.
  task automatic send_item(input kind_t k, input logic [NODE_W-1:0] nd,
                           input logic [NODE_W-1:0] nb, input logic [LEN_IN_W-1:0] len,
                           input bit typed, input route_t want);
    int gap;
    int i;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    node <= nd;
    neighbor <= nb;
    length <= len;
    do @(posedge clk); while (!in_ready);
    case (k)
      KIND_LOAD: begin
        seg_len[nd] = len;
      end
      KIND_CONNECT: begin
        links[nd][nb] = 1'b1;
      end
      KIND_CLEAR: begin
        for (i = 0; i < NODES; i++) links[i] = '0;
      end
      default: begin
        if (typed) pending_routes = {pending_routes, want};
        else predict_routes(nd);
      end
    endcase
  endtask

  // Bring the block to rest: stop offering items, let every queued route come out, then
  // leave room for a connection write that may still be in progress.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [CFG_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    node_count_q = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random item over the nodes in use. Most items stay in range so that runs find real
  // paths; a tenth may name any node, which also gives sources and targets not in use.
  // Short lengths are frequent, so that equal costs and ties show up.
  task automatic random_item();
    int pick;
    int n;
    kind_t k;
    logic [NODE_W-1:0] nd;
    logic [NODE_W-1:0] nb;
    logic [LEN_IN_W-1:0] len;
    n = nodes_used(node_count_q);
    pick = $urandom_range(99);
    if (pick < 30) k = KIND_LOAD;
    else if (pick < 80) k = KIND_CONNECT;
    else if (pick < 83) k = KIND_CLEAR;
    else k = KIND_RUN;
    nd = ($urandom_range(9) == 0) ? NODE_W'($urandom_range(NODES - 1))
                                  : NODE_W'($urandom_range(n - 1));
    nb = ($urandom_range(9) == 0) ? NODE_W'($urandom_range(NODES - 1))
                                  : NODE_W'($urandom_range(n - 1));
    len = ($urandom_range(2) == 0) ? LEN_IN_W'($urandom_range(3)) : LEN_IN_W'($urandom);
    send_item(k, nd, nb, len, 1'b0, NO_ROUTE);
  endtask

  // Each result accepted by the receiver is matched with the oldest queued route.
  always @(posedge clk) begin
    route_t got;
    route_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{dest: dest, pred: predecessor, hop: first_hop, cost: path_cost,
              reach: reachable, last: last};
      if (pending_routes.size() == 0) begin
        error_count++;
        if (error_count <= SHOWN_MAX)
          $display("unexpected result: dest %0d pred %0d hop %0d cost %0d reach %0d last %0d",
                   got.dest, got.pred, got.hop, got.cost, got.reach, got.last);
      end else begin
        want = pending_routes.pop_front();
        if (got.dest != want.dest || got.pred != want.pred || got.hop != want.hop ||
            got.cost != want.cost || got.reach != want.reach || got.last != want.last) begin
          error_count++;
          if (error_count <= SHOWN_MAX) begin
            $display("mismatch: expected dest %0d pred %0d hop %0d cost %0d reach %0d last %0d",
                     want.dest, want.pred, want.hop, want.cost, want.reach, want.last);
            $display("          actual   dest %0d pred %0d hop %0d cost %0d reach %0d last %0d",
                     got.dest, got.pred, got.hop, got.cost, got.reach, got.last);
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int i;
    int p;
    int waited;
    for (i = 0; i < NODES; i++) begin
      seg_len[i] = '0;
      links[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with neither side idling.
    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].cfg_first) write_node_count(DIRECTED[i].cfg_value);
      send_item(DIRECTED[i].kind, DIRECTED[i].node, DIRECTED[i].neighbor,
                DIRECTED[i].length, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random phases. Each sets a new node count and cycles through the idling patterns:
    // none, a slow sender, a slow receiver, and both moderately slow.
    for (p = 0; p < PHASES; p++) begin
      write_node_count(PHASE_COUNTS[p]);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 80;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 80;
        end
        default: begin
          gap_pct = 35;
          stall_pct = 35;
        end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_routes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_routes.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", pending_routes.size());
    end
    if (error_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

### sim.f
hdl/spnh_pkg.sv
hdl/spnh_relax_unit.sv
hdl/shortest_path_next_hop_core.sv
verif/testbench.sv
